// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("Assertion lbl failed.");

// Checks a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("Assertion lbl failed.");

`endif

// ----- hw/rtl/sdqc_pkg.sv -----
// Types and constants of the session demultiplexer with query credit.
package sdqc_pkg;

  localparam int unsigned SESSIONS_DEF = 16;
  localparam int unsigned FIFO_DEPTH   = 4;

  localparam int unsigned ENTRY_W    = 4;
  localparam int unsigned SID_W      = 16;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned LANE_W     = 32;
  localparam int unsigned QF_W       = 12;
  localparam int unsigned BYTES_W    = 48;
  localparam int unsigned PEND_W     = 24;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned CFG_IDX_W  = 1;

  // A packet of 64 bytes carries 16 float words.
  localparam int unsigned BLOCK_SHIFT = 6;
  localparam int unsigned FLOAT_SHIFT = 4;

  localparam logic [QF_W-1:0] QF_RESET = QF_W'(128);

  typedef enum logic {
    FUNC_HEADER = 1'b0,
    FUNC_DATA   = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUERY_FLOATS   = 1'b0,
    CFG_EXPECTED_BYTES = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    func_e              func;
    logic               full;
    logic               fresh;
    logic [SID_W-1:0]   sid;
    logic [LEN_W-1:0]   len;
    logic [LANE_W-1:0]  lane;
  } cmd_t;

endpackage

// ----- hw/rtl/sdqc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module sdqc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/sdqc_front.sv -----
// Front end: accepts items, looks up or allocates session entries, tags data lanes.
module sdqc_front #(
  parameter int unsigned SESSIONS = 16,
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned USED_W   = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      func_i,
  input  logic [sdqc_pkg::SID_W-1:0]  session_id_i,
  input  logic [sdqc_pkg::LEN_W-1:0]  byte_length_i,
  input  logic [sdqc_pkg::LANE_W-1:0] data_lane_i,
  input  logic                      fifo_full_i,
  output logic                      push_o,
  output sdqc_pkg::cmd_t            cmd_o,
  output logic [IDX_W-1:0]          idx_o
);
  import sdqc_pkg::*;

  logic [SID_W-1:0]  tbl_q [SESSIONS];
  logic [USED_W-1:0] used_q, used_d;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic [IDX_W-1:0]  hit_idx;
  logic              hit, alloc, full, accept;
  func_e             func;

  assign func   = func_e'(func_i);
  assign accept = in_valid_i && !fifo_full_i;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = SESSIONS - 1; i >= 0; i--) begin
      if ((USED_W'(i) < used_q) && (tbl_q[i] == session_id_i)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign alloc = !hit && (used_q != USED_W'(SESSIONS));
  assign full  = !hit && !alloc;

  always_comb begin
    cmd_o.func  = func;
    cmd_o.full  = 1'b0;
    cmd_o.fresh = 1'b0;
    cmd_o.sid   = session_id_i;
    cmd_o.len   = byte_length_i;
    cmd_o.lane  = data_lane_i;
    idx_o       = cur_q;
    used_d      = used_q;
    cur_d       = cur_q;
    unique case (func)
      FUNC_HEADER: begin
        cmd_o.full  = full;
        cmd_o.fresh = alloc;
        if (hit) begin
          idx_o = hit_idx;
        end else if (alloc) begin
          idx_o = used_q[IDX_W-1:0];
        end else begin
          idx_o = '0;
        end
        if (accept && !full) begin
          cur_d = idx_o;
        end
        if (accept && alloc) begin
          used_d = used_q + USED_W'(1);
        end
      end
      FUNC_DATA: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept && func == FUNC_HEADER && alloc) begin
      tbl_q[used_q[IDX_W-1:0]] <= session_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      cur_q  <= '0;
    end else begin
      used_q <= used_d;
      cur_q  <= cur_d;
    end
  end

  assign push_o     = accept;
  assign in_stall_o = fifo_full_i;

endmodule

// ----- hw/rtl/sdqc_fifo.sv -----
// Short queue between the front end and the back end.
module sdqc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- hw/rtl/sdqc_back.sv -----
// Back end: pending float credit, received byte total and the result register.
module sdqc_back #(
  parameter int unsigned SESSIONS = 16,
  parameter int unsigned IDX_W    = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sdqc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sdqc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            fifo_empty_i,
  input  sdqc_pkg::cmd_t                  fifo_cmd_i,
  input  logic [IDX_W-1:0]                fifo_idx_i,
  output logic                            fifo_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            kind_o,
  output logic [sdqc_pkg::ENTRY_W-1:0]    entry_o,
  output logic [sdqc_pkg::SID_W-1:0]      ready_session_id_o,
  output logic                            query_ready_o,
  output logic                            new_session_o,
  output logic                            table_full_o,
  output logic [sdqc_pkg::LANE_W-1:0]     routed_lane_o,
  output logic                            all_received_o
);
  import sdqc_pkg::*;

  localparam int unsigned BLK_W = LEN_W - BLOCK_SHIFT + FLOAT_SHIFT;

  logic [QF_W-1:0]    qf_q;
  logic [BYTES_W-1:0] exp_q, bytes_q, bytes_d;
  logic [SESSIONS-1:0] vld_q;

  cmd_t               s2_cmd_q;
  logic [IDX_W-1:0]   s2_idx_q;
  logic               s2_v_q, s2_adv, s2_load;

  logic               lw_v_q;
  logic [IDX_W-1:0]   lw_idx_q;
  logic [PEND_W-1:0]  lw_data_q;

  logic [PEND_W-1:0]  ram_rdata, pend, cnt, new_cnt, qf_ext;
  logic [PEND_W:0]    psum;
  logic [BLK_W-1:0]   blk;
  logic [BYTES_W:0]   bsum;
  logic               ready, is_hdr, do_wr;

  logic               out_v_q;
  logic               kind_q, ready_q, fresh_q, full_q, all_q;
  logic [ENTRY_W-1:0] entry_q;
  logic [SID_W-1:0]   rsid_q;
  logic [LANE_W-1:0]  lane_q;

  assign s2_adv     = s2_v_q && (!out_v_q || !out_stall_i);
  assign s2_load    = !s2_v_q || s2_adv;
  assign fifo_pop_o = !fifo_empty_i && s2_load;

  sdqc_ram #(
    .WIDTH (PEND_W),
    .DEPTH (SESSIONS),
    .AW    (IDX_W)
  ) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (do_wr),
    .waddr_i (s2_idx_q),
    .wdata_i (new_cnt),
    .re_i    (fifo_pop_o),
    .raddr_i (fifo_idx_i),
    .rdata_o (ram_rdata)
  );

  // The most recent write is forwarded because the RAM read was issued when the item left the queue, with that write.
  always_comb begin
    if (lw_v_q && lw_idx_q == s2_idx_q) begin
      pend = lw_data_q;
    end else if (vld_q[s2_idx_q]) begin
      pend = ram_rdata;
    end else begin
      pend = '0;
    end
  end

  assign is_hdr  = (s2_cmd_q.func == FUNC_HEADER);
  assign blk     = {s2_cmd_q.len[LEN_W-1:BLOCK_SHIFT], {FLOAT_SHIFT{1'b0}}};
  assign psum    = {1'b0, pend} + (PEND_W + 1)'(blk);
  assign cnt     = psum[PEND_W] ? '1 : psum[PEND_W-1:0];
  assign qf_ext  = PEND_W'(qf_q);
  assign ready   = (cnt >= qf_ext);
  assign new_cnt = ready ? cnt - qf_ext : cnt;
  assign do_wr   = s2_adv && is_hdr && !s2_cmd_q.full;

  assign bsum = {1'b0, bytes_q} + (BYTES_W + 1)'(s2_cmd_q.len);

  always_comb begin
    bytes_d = bytes_q;
    if (is_hdr) begin
      bytes_d = bsum[BYTES_W] ? '1 : bsum[BYTES_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qf_q  <= QF_RESET;
      exp_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_QUERY_FLOATS:   qf_q  <= cfg_data_i[QF_W-1:0];
        CFG_EXPECTED_BYTES: exp_q <= cfg_data_i[BYTES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (fifo_pop_o) begin
      s2_cmd_q <= fifo_cmd_i;
      s2_idx_q <= fifo_idx_i;
    end
    if (do_wr) begin
      lw_idx_q  <= s2_idx_q;
      lw_data_q <= new_cnt;
    end
    if (s2_adv) begin
      kind_q  <= s2_cmd_q.func;
      entry_q <= ENTRY_W'(s2_idx_q);
      ready_q <= is_hdr && !s2_cmd_q.full && ready;
      rsid_q  <= (is_hdr && !s2_cmd_q.full && ready) ? s2_cmd_q.sid : '0;
      fresh_q <= is_hdr && s2_cmd_q.fresh;
      full_q  <= is_hdr && s2_cmd_q.full;
      lane_q  <= is_hdr ? '0 : s2_cmd_q.lane;
      all_q   <= (bytes_d >= exp_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      lw_v_q  <= 1'b0;
      vld_q   <= '0;
      bytes_q <= '0;
    end else begin
      if (s2_load) begin
        s2_v_q <= fifo_pop_o;
      end
      if (s2_adv) begin
        out_v_q <= 1'b1;
        bytes_q <= bytes_d;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
      if (do_wr) begin
        lw_v_q          <= 1'b1;
        vld_q[s2_idx_q] <= 1'b1;
      end
    end
  end

  assign out_valid_o        = out_v_q;
  assign kind_o             = kind_q;
  assign entry_o            = entry_q;
  assign ready_session_id_o = rsid_q;
  assign query_ready_o      = ready_q;
  assign new_session_o      = fresh_q;
  assign table_full_o       = full_q;
  assign routed_lane_o      = lane_q;
  assign all_received_o     = all_q;

endmodule

// ----- hw/rtl/session_demux_with_query_credit_unit.sv -----
// Top level of the session demultiplexer with query credit.
// The block takes one item per cycle while the queue is not full, and delivers exactly one
// result per item, in order. The front end compares all session entries in parallel and
// writes the item into the queue when it is accepted. From the queue it moves into the back
// end's stage register while the pending-float RAM is read, and from there into the result
// register. The queue holds four items, so either side can stall without stopping the other
// at once.
// Pending counts are cleared by per-entry valid bits at reset, so no clearing pass is needed.
module session_demux_with_query_credit_unit #(
  parameter int unsigned SESSIONS = sdqc_pkg::SESSIONS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sdqc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sdqc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            func_i,
  input  logic [sdqc_pkg::SID_W-1:0]      session_id_i,
  input  logic [sdqc_pkg::LEN_W-1:0]      byte_length_i,
  input  logic [sdqc_pkg::LANE_W-1:0]     data_lane_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            kind_o,
  output logic [sdqc_pkg::ENTRY_W-1:0]    entry_o,
  output logic [sdqc_pkg::SID_W-1:0]      ready_session_id_o,
  output logic                            query_ready_o,
  output logic                            new_session_o,
  output logic                            table_full_o,
  output logic [sdqc_pkg::LANE_W-1:0]     routed_lane_o,
  output logic                            all_received_o
);
  import sdqc_pkg::*;

  localparam int unsigned IDX_W  = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam int unsigned USED_W = $clog2(SESSIONS + 1);
  localparam int unsigned QW     = $bits(cmd_t) + IDX_W;

  cmd_t             f_cmd, b_cmd;
  logic [IDX_W-1:0] f_idx, b_idx;
  logic             push, pop, q_full, q_empty;

  sdqc_front #(
    .SESSIONS (SESSIONS),
    .IDX_W    (IDX_W),
    .USED_W   (USED_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .session_id_i  (session_id_i),
    .byte_length_i (byte_length_i),
    .data_lane_i   (data_lane_i),
    .fifo_full_i   (q_full),
    .push_o        (push),
    .cmd_o         (f_cmd),
    .idx_o         (f_idx)
  );

  sdqc_fifo #(
    .WIDTH (QW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_cmd, f_idx}),
    .pop_i   (pop),
    .data_o  ({b_cmd, b_idx}),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  sdqc_back #(
    .SESSIONS (SESSIONS),
    .IDX_W    (IDX_W)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .fifo_empty_i       (q_empty),
    .fifo_cmd_i         (b_cmd),
    .fifo_idx_i         (b_idx),
    .fifo_pop_o         (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .kind_o             (kind_o),
    .entry_o            (entry_o),
    .ready_session_id_o (ready_session_id_o),
    .query_ready_o      (query_ready_o),
    .new_session_o      (new_session_o),
    .table_full_o       (table_full_o),
    .routed_lane_o      (routed_lane_o),
    .all_received_o     (all_received_o)
  );

endmodule

// ----- hw/rtl/sdqc_checker.sv -----
// Port-level assertions for the session demultiplexer and the bind that attaches them.
`include "assert_macros.svh"

module sdqc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            kind_o,
  input logic [sdqc_pkg::ENTRY_W-1:0]    entry_o,
  input logic [sdqc_pkg::SID_W-1:0]      ready_session_id_o,
  input logic                            query_ready_o,
  input logic                            new_session_o,
  input logic                            table_full_o,
  input logic [sdqc_pkg::LANE_W-1:0]     routed_lane_o
);

  `ASSERT_ALWAYS(a_no_valid_in_reset, clk_i, !rst_ni |=> !out_valid_o)

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(entry_o) && $stable(routed_lane_o))

  `ASSERT_CLK(a_data_has_no_flags, clk_i, rst_ni,
    out_valid_o && kind_o |-> !query_ready_o && !new_session_o && !table_full_o)

  `ASSERT_CLK(a_full_excludes_new, clk_i, rst_ni,
    out_valid_o && table_full_o |-> !new_session_o && !query_ready_o && entry_o == '0)

  `ASSERT_CLK(a_ready_id_only_on_notice, clk_i, rst_ni,
    out_valid_o && (ready_session_id_o != '0) |-> query_ready_o)

endmodule

bind session_demux_with_query_credit_unit sdqc_checker u_sdqc_checker (.*);
